// ===== rtl/mcfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mcfe_pkg;

  // Field and register widths
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned LIM_W       = 31;
  localparam int unsigned NUM_IN      = 5;
  localparam int unsigned IN_W        = NUM_IN * DATA_W;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned NUM_OUT     = 8;
  localparam int unsigned OUT_W       = NUM_OUT * BYTE_W;
  localparam int unsigned IDX_W       = 3;

  // Code widths of the payload
  localparam int unsigned POS_CODE_W  = 16;
  localparam int unsigned GAIN_CODE_W = 12;

  // Pipeline shape: clamp, offset, scale, then one quotient bit per stage
  localparam int unsigned QUOT_W      = 16;
  localparam int unsigned PRE_STG     = 3;
  localparam int unsigned NSTG        = PRE_STG + QUOT_W;
  localparam int unsigned CNT_W       = $clog2(NSTG + 1);

  // Register reset values
  localparam logic [LIM_W-1:0] POS_LIMIT_RST = LIM_W'(819200);
  localparam logic [LIM_W-1:0] VEL_LIMIT_RST = LIM_W'(1966080);
  localparam logic [LIM_W-1:0] TRQ_LIMIT_RST = LIM_W'(655360);
  localparam logic [LIM_W-1:0] KP_MAX_RST    = LIM_W'(32768000);
  localparam logic [LIM_W-1:0] KD_MAX_RST    = LIM_W'(327680);

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_POS_LIMIT,
    REG_VEL_LIMIT,
    REG_TRQ_LIMIT,
    REG_KP_MAX,
    REG_KD_MAX,
    REG_STOPPED
  } reg_idx_e;

  // Per-stage advance enables shared by all lanes
  typedef logic [NSTG-1:0] stage_en_t;

endpackage

`default_nettype wire

// ===== rtl/mcfe_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcfe_lane #(
  parameter int unsigned CODE_W    = 12,
  parameter bit          SYMMETRIC = 1'b1
) (
  input  logic                                 clk_i,
  input  mcfe_pkg::stage_en_t                  en_i,
  input  logic signed [mcfe_pkg::DATA_W-1:0]   x_i,
  input  logic        [mcfe_pkg::LIM_W-1:0]    lim_i,
  output logic        [CODE_W-1:0]             code_o
);
  import mcfe_pkg::*;

  localparam int unsigned XW = DATA_W + 1;
  localparam int unsigned DW = DATA_W + QUOT_W;

  // Stage 1: clamp
  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] hi_c;
  logic signed [XW-1:0] lo_c;
  logic signed [XW-1:0] xc_d;
  logic signed [XW-1:0] xc_q;
  logic [LIM_W-1:0]     lim1_q;

  assign x_ext = XW'(x_i);
  assign hi_c  = signed'({2'b00, lim_i});
  assign lo_c  = SYMMETRIC ? -hi_c : '0;

  always_comb begin
    if (x_ext < lo_c) begin
      xc_d = lo_c;
    end else if (x_ext > hi_c) begin
      xc_d = hi_c;
    end else begin
      xc_d = x_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      xc_q   <= xc_d;
      lim1_q <= lim_i;
    end
  end

  // Stage 2: offset from the range low end, span and empty-range flag
  logic signed [XW-1:0] lo2;
  logic signed [XW-1:0] off_d;
  logic [DATA_W-1:0]    off_q;
  logic [DATA_W-1:0]    span2_q;
  logic                 zero2_q;

  assign lo2   = SYMMETRIC ? -signed'({2'b00, lim1_q}) : '0;
  assign off_d = xc_q - lo2;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      off_q   <= off_d[DATA_W-1:0];
      span2_q <= SYMMETRIC ? {lim1_q, 1'b0} : {1'b0, lim1_q};
      zero2_q <= (lim1_q == '0);
    end
  end

  // Stage 3: scale by the level count (2^CODE_W - 1) as shift and subtract
  logic [DW-1:0] prod_d;

  assign prod_d = (DW'(off_q) << CODE_W) - DW'(off_q);

  logic [DATA_W-1:0] rem_q  [QUOT_W+1];
  logic [QUOT_W-1:0] low_q  [QUOT_W+1];
  logic [QUOT_W-1:0] quo_q  [QUOT_W+1];
  logic [DATA_W-1:0] span_q [QUOT_W+1];
  logic              zero_q [QUOT_W+1];

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      rem_q[0]  <= prod_d[DW-1:QUOT_W];
      low_q[0]  <= prod_d[QUOT_W-1:0];
      quo_q[0]  <= '0;
      span_q[0] <= span2_q;
      zero_q[0] <= zero2_q;
    end
  end

  // Restoring division, one quotient bit per stage; the upper part of the
  // dividend is already below the span since the quotient fits QUOT_W bits
  for (genvar j = 0; j < QUOT_W; j++) begin : g_div
    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;

    assign trial = {rem_q[j], low_q[j][QUOT_W-1]};
    assign diff  = trial - {1'b0, span_q[j]};

    always_ff @(posedge clk_i) begin
      if (en_i[PRE_STG+j]) begin
        if (trial >= {1'b0, span_q[j]}) begin
          rem_q[j+1] <= diff[DATA_W-1:0];
          quo_q[j+1] <= {quo_q[j][QUOT_W-2:0], 1'b1};
        end else begin
          rem_q[j+1] <= trial[DATA_W-1:0];
          quo_q[j+1] <= {quo_q[j][QUOT_W-2:0], 1'b0};
        end
        low_q[j+1]  <= {low_q[j][QUOT_W-2:0], 1'b0};
        span_q[j+1] <= span_q[j];
        zero_q[j+1] <= zero_q[j];
      end
    end
  end

  // An empty range always codes to zero
  assign code_o = zero_q[QUOT_W] ? '0 : quo_q[QUOT_W][CODE_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/mit_command_frame_encoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// MIT-mode motor command encoder: each transfer on the slave stream carries one
// command (position, velocity, stiffness, damping, torque, signed Q16.16) and
// yields one 8-byte CAN payload on the master stream. Values are forced to zero
// while the stopped register is set, clamped to their configured ranges and
// quantized as floor(offset * (2^bits - 1) / span), 16 bits for position and
// 12 bits for the rest. The block takes one command per cycle unless backpressure
// has filled its stages; a result passes clamp, offset, scale, then a 16-stage
// restoring divider per value that produces one quotient bit per stage. Every stage
// holds its item under backpressure while empty stages upstream keep filling.
// Write the configuration registers only while no command is in flight.
module mit_command_frame_encoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // fields from bit 0: target_position, target_velocity, stiffness, damping,
  // torque_command, 32 bits each
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mcfe_pkg::IN_W-1:0]     s_axis_tdata,
  // fields from bit 0: byte0 .. byte7, 8 bits each
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mcfe_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [mcfe_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [mcfe_pkg::LIM_W-1:0]    cfg_wdata_i
);
  import mcfe_pkg::*;

  // Configuration registers
  logic [LIM_W-1:0] pos_limit_q;
  logic [LIM_W-1:0] vel_limit_q;
  logic [LIM_W-1:0] trq_limit_q;
  logic [LIM_W-1:0] kp_max_q;
  logic [LIM_W-1:0] kd_max_q;
  logic             stopped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_limit_q <= POS_LIMIT_RST;
      vel_limit_q <= VEL_LIMIT_RST;
      trq_limit_q <= TRQ_LIMIT_RST;
      kp_max_q    <= KP_MAX_RST;
      kd_max_q    <= KD_MAX_RST;
      stopped_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_POS_LIMIT: pos_limit_q <= cfg_wdata_i;
        REG_VEL_LIMIT: vel_limit_q <= cfg_wdata_i;
        REG_TRQ_LIMIT: trq_limit_q <= cfg_wdata_i;
        REG_KP_MAX:    kp_max_q    <= cfg_wdata_i;
        REG_KD_MAX:    kd_max_q    <= cfg_wdata_i;
        REG_STOPPED:   stopped_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Stage valid bits; a stage advances when empty or when its successor does
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] vld_d;
  stage_en_t       en;

  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = s_axis_tvalid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NSTG-1];

  // Drop the command to zero while stopped
  logic signed [DATA_W-1:0] cmd [NUM_IN];

  for (genvar i = 0; i < NUM_IN; i++) begin : g_cmd
    assign cmd[i] = stopped_q ? '0 : signed'(s_axis_tdata[i*DATA_W +: DATA_W]);
  end

  // Quantizer lanes
  logic [POS_CODE_W-1:0]  pos_code;
  logic [GAIN_CODE_W-1:0] vel_code;
  logic [GAIN_CODE_W-1:0] kp_code;
  logic [GAIN_CODE_W-1:0] kd_code;
  logic [GAIN_CODE_W-1:0] trq_code;

  mcfe_lane #(.CODE_W(POS_CODE_W), .SYMMETRIC(1'b1)) u_pos (
    .clk_i (clk_i), .en_i (en), .x_i (cmd[0]), .lim_i (pos_limit_q), .code_o (pos_code)
  );
  mcfe_lane #(.CODE_W(GAIN_CODE_W), .SYMMETRIC(1'b1)) u_vel (
    .clk_i (clk_i), .en_i (en), .x_i (cmd[1]), .lim_i (vel_limit_q), .code_o (vel_code)
  );
  mcfe_lane #(.CODE_W(GAIN_CODE_W), .SYMMETRIC(1'b0)) u_kp (
    .clk_i (clk_i), .en_i (en), .x_i (cmd[2]), .lim_i (kp_max_q), .code_o (kp_code)
  );
  mcfe_lane #(.CODE_W(GAIN_CODE_W), .SYMMETRIC(1'b0)) u_kd (
    .clk_i (clk_i), .en_i (en), .x_i (cmd[3]), .lim_i (kd_max_q), .code_o (kd_code)
  );
  mcfe_lane #(.CODE_W(GAIN_CODE_W), .SYMMETRIC(1'b1)) u_trq (
    .clk_i (clk_i), .en_i (en), .x_i (cmd[4]), .lim_i (trq_limit_q), .code_o (trq_code)
  );

  // Pack the payload, byte0 in the lowest bits
  assign m_axis_tdata = {
    trq_code[7:0],
    kd_code[3:0], trq_code[11:8],
    kd_code[11:4],
    kp_code[7:0],
    vel_code[3:0], kp_code[11:8],
    vel_code[11:4],
    pos_code[7:0],
    pos_code[15:8]
  };

endmodule

`default_nettype wire

// ===== rtl/mcfe_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcfe_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [mcfe_pkg::OUT_W-1:0]    m_axis_tdata
);
  import mcfe_pkg::*;

  // Track commands accepted but not yet delivered
  logic [CNT_W-1:0] cnt_q;
  logic             s_xfer;
  logic             m_xfer;

  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign m_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (s_xfer && !m_xfer) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (m_xfer && !s_xfer) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // Nothing is offered in the cycle after a reset edge
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result offered after reset");

  // A waiting result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // The input side is open whenever the output side can drain
  a_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output free");

  // No result without an outstanding command, and never more than the depth
  a_outstanding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid |-> cnt_q != '0) && (cnt_q <= CNT_W'(NSTG)))
    else $error("result count out of step with commands");

endmodule

bind mit_command_frame_encoder_core mcfe_checker u_mcfe_checker (.*);

`default_nettype wire
